// File: rtl/fdsh_pkg.sv
`timescale 1ns / 1ps
// Package for the stepped fan duty controller.
// Holds register indexes, reset thresholds, the threshold bundle type and level tables.
package fdsh_pkg;

    localparam int unsigned TEMP_W  = 18;
    localparam int unsigned FAULT_W = 8;
    localparam int unsigned CODE_W  = 5;
    localparam int unsigned PCT_W   = 7;
    localparam int unsigned LEVEL_W = 2;
    localparam int unsigned CFG_IDX_W = 3;

    typedef logic signed [TEMP_W-1:0] t_temp;
    typedef logic [LEVEL_W-1:0]       t_level;

    localparam t_level LEVEL_MIN = 2'd0;
    localparam t_level LEVEL_MAX = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_UP_LEVEL0   = 3'd0,
        REG_UP_LEVEL1   = 3'd1,
        REG_UP_LEVEL2   = 3'd2,
        REG_DOWN_LEVEL1 = 3'd3,
        REG_DOWN_LEVEL2 = 3'd4,
        REG_DOWN_LEVEL3 = 3'd5
    } t_cfg_index;

    localparam t_temp RST_UP_LEVEL0   = 18'sd46500;
    localparam t_temp RST_UP_LEVEL1   = 18'sd50000;
    localparam t_temp RST_UP_LEVEL2   = 18'sd54700;
    localparam t_temp RST_DOWN_LEVEL1 = 18'sd42700;
    localparam t_temp RST_DOWN_LEVEL2 = 18'sd47700;
    localparam t_temp RST_DOWN_LEVEL3 = 18'sd52700;

    typedef struct packed {
        t_temp up_level0;
        t_temp up_level1;
        t_temp up_level2;
        t_temp down_level1;
        t_temp down_level2;
        t_temp down_level3;
    } t_thresholds;

    localparam logic [CODE_W-1:0] CODE_LEVEL0 = 5'h0a;
    localparam logic [CODE_W-1:0] CODE_LEVEL1 = 5'h0d;
    localparam logic [CODE_W-1:0] CODE_LEVEL2 = 5'h10;
    localparam logic [CODE_W-1:0] CODE_LEVEL3 = 5'h14;

    localparam logic [PCT_W-1:0] PCT_LEVEL0 = 7'd50;
    localparam logic [PCT_W-1:0] PCT_LEVEL1 = 7'd65;
    localparam logic [PCT_W-1:0] PCT_LEVEL2 = 7'd80;
    localparam logic [PCT_W-1:0] PCT_LEVEL3 = 7'd100;

    function automatic logic [CODE_W-1:0] level_code(input t_level lvl);
        logic [CODE_W-1:0] code;
        unique case (lvl)
            2'd0:    code = CODE_LEVEL0;
            2'd1:    code = CODE_LEVEL1;
            2'd2:    code = CODE_LEVEL2;
            default: code = CODE_LEVEL3;
        endcase
        return code;
    endfunction

    function automatic logic [PCT_W-1:0] level_pct(input t_level lvl);
        logic [PCT_W-1:0] pct;
        unique case (lvl)
            2'd0:    pct = PCT_LEVEL0;
            2'd1:    pct = PCT_LEVEL1;
            2'd2:    pct = PCT_LEVEL2;
            default: pct = PCT_LEVEL3;
        endcase
        return pct;
    endfunction

endpackage

// File: rtl/fdsh_in_if.sv
`timescale 1ns / 1ps
// Input channel of the fan duty controller: one polling tick per word.
// Depends on fdsh_pkg.
interface fdsh_in_if;
    logic                          valid;
    logic                          ready;
    logic [fdsh_pkg::FAULT_W-1:0]  fault_status;
    logic                          temps_ok;
    fdsh_pkg::t_temp               temp_a;
    fdsh_pkg::t_temp               temp_b;

    modport source (output valid, fault_status, temps_ok, temp_a, temp_b, input ready);
    modport sink   (input valid, fault_status, temps_ok, temp_a, temp_b, output ready);
endinterface

// File: rtl/fdsh_out_if.sv
`timescale 1ns / 1ps
// Result channel of the fan duty controller: one duty word per tick.
// Depends on fdsh_pkg.
interface fdsh_out_if;
    logic                         valid;
    logic                         ready;
    logic [fdsh_pkg::CODE_W-1:0]  duty_code;
    logic [fdsh_pkg::PCT_W-1:0]   duty_percent;
    logic                         write_issued;

    modport source (output valid, duty_code, duty_percent, write_issued, input ready);
    modport sink   (input valid, duty_code, duty_percent, write_issued, output ready);
endinterface

// File: rtl/fdsh_cfg_regs.sv
`timescale 1ns / 1ps
// Threshold register file of the fan duty controller.
// Depends on fdsh_pkg.
module fdsh_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [fdsh_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fdsh_pkg::TEMP_W-1:0]      i_cfg_data,
    output fdsh_pkg::t_thresholds            o_thr
);

    fdsh_pkg::t_thresholds r_thr;
    fdsh_pkg::t_thresholds n_thr;

    always_comb begin
        n_thr = r_thr;
        if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                fdsh_pkg::REG_UP_LEVEL0:   n_thr.up_level0   = i_cfg_data;
                fdsh_pkg::REG_UP_LEVEL1:   n_thr.up_level1   = i_cfg_data;
                fdsh_pkg::REG_UP_LEVEL2:   n_thr.up_level2   = i_cfg_data;
                fdsh_pkg::REG_DOWN_LEVEL1: n_thr.down_level1 = i_cfg_data;
                fdsh_pkg::REG_DOWN_LEVEL2: n_thr.down_level2 = i_cfg_data;
                fdsh_pkg::REG_DOWN_LEVEL3: n_thr.down_level3 = i_cfg_data;
                default:                   n_thr = r_thr;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.up_level0   <= fdsh_pkg::RST_UP_LEVEL0;
            r_thr.up_level1   <= fdsh_pkg::RST_UP_LEVEL1;
            r_thr.up_level2   <= fdsh_pkg::RST_UP_LEVEL2;
            r_thr.down_level1 <= fdsh_pkg::RST_DOWN_LEVEL1;
            r_thr.down_level2 <= fdsh_pkg::RST_DOWN_LEVEL2;
            r_thr.down_level3 <= fdsh_pkg::RST_DOWN_LEVEL3;
        end else begin
            r_thr <= n_thr;
        end
    end

    assign o_thr = r_thr;

endmodule

// File: rtl/fdsh_level_step.sv
`timescale 1ns / 1ps
// Next duty level from fault byte, sensor average and hysteresis thresholds.
// Depends on fdsh_pkg.
module fdsh_level_step (
    input  fdsh_pkg::t_level                 i_level,
    input  logic [fdsh_pkg::FAULT_W-1:0]     i_fault_status,
    input  logic                             i_temps_ok,
    input  fdsh_pkg::t_temp                  i_temp_a,
    input  fdsh_pkg::t_temp                  i_temp_b,
    input  fdsh_pkg::t_thresholds            i_thr,
    output fdsh_pkg::t_level                 o_level,
    output logic                             o_write_issued
);

    localparam int unsigned SUM_W = fdsh_pkg::TEMP_W + 1;

    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] sum_adj;
    fdsh_pkg::t_temp         avg;
    fdsh_pkg::t_temp         up_thr;
    fdsh_pkg::t_temp         down_thr;
    logic                    step_up;
    logic                    step_down;

    // truncate toward zero: bias negative sums by one before the shift
    assign sum     = SUM_W'(i_temp_a) + SUM_W'(i_temp_b);
    assign sum_adj = sum + $signed({{(SUM_W-1){1'b0}}, sum[SUM_W-1]});
    assign avg     = fdsh_pkg::t_temp'(sum_adj >>> 1);

    always_comb begin
        case (i_level)
            2'd0:    begin up_thr = i_thr.up_level0; down_thr = i_thr.down_level1; end
            2'd1:    begin up_thr = i_thr.up_level1; down_thr = i_thr.down_level1; end
            2'd2:    begin up_thr = i_thr.up_level2; down_thr = i_thr.down_level2; end
            default: begin up_thr = i_thr.up_level2; down_thr = i_thr.down_level3; end
        endcase
    end

    assign step_up   = (i_level != fdsh_pkg::LEVEL_MAX) && (avg >= up_thr);
    assign step_down = (i_level != fdsh_pkg::LEVEL_MIN) && (avg <= down_thr);

    always_comb begin
        o_level        = i_level;
        o_write_issued = 1'b0;
        if (i_fault_status != '0) begin
            o_level        = fdsh_pkg::LEVEL_MAX;
            o_write_issued = 1'b1;
        end else if (i_temps_ok) begin
            o_write_issued = 1'b1;
            if (step_up) begin
                o_level = i_level + 2'd1;
            end else if (step_down) begin
                o_level = i_level - 2'd1;
            end
        end
    end

endmodule

// File: rtl/fan_duty_step_hysteresis_control_core.sv
`timescale 1ns / 1ps
// Top level of the stepped fan duty controller with hysteresis.
// Depends on fdsh_pkg, fdsh_in_if, fdsh_out_if, fdsh_cfg_regs, fdsh_level_step.
//
// Usage:
//   i_in carries one polling tick per word: fault byte, read-ok flag and two
//   sensor temperatures in millidegrees C. o_out returns exactly one word per
//   tick: PWM code, duty percent and whether a PWM write is made.
//   The threshold registers are written through i_cfg_wr_en / i_cfg_index /
//   i_cfg_data, one register per cycle; the user must write them only while
//   no tick is in flight; the block itself does not enforce this.
//   Path: input register, then one pass of level logic into the result register.
//   Throughput: one word per cycle while o_out is not stalled; the duty level
//   register is the only loop and it closes in that single pass.
//   Reset: level returns to 50 percent, thresholds to their defaults, both
//   pipeline registers empty.
//   Stall: a held result keeps o_out stable; the input register still takes
//   one more word, then i_in.ready drops until the result is taken.
module fan_duty_step_hysteresis_control_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    fdsh_in_if.sink                          i_in,
    fdsh_out_if.source                       o_out,
    input  logic                             i_cfg_wr_en,
    input  logic [fdsh_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fdsh_pkg::TEMP_W-1:0]      i_cfg_data
);

    fdsh_pkg::t_thresholds              thr;

    logic                               r_in_valid;
    logic [fdsh_pkg::FAULT_W-1:0]       r_fault_status;
    logic                               r_temps_ok;
    fdsh_pkg::t_temp                    r_temp_a;
    fdsh_pkg::t_temp                    r_temp_b;

    fdsh_pkg::t_level                   r_level;
    fdsh_pkg::t_level                   n_level;
    logic                               n_write_issued;

    logic                               r_out_valid;
    logic [fdsh_pkg::CODE_W-1:0]        r_duty_code;
    logic [fdsh_pkg::PCT_W-1:0]         r_duty_percent;
    logic                               r_write_issued;

    logic                               advance;
    logic                               in_fire;

    fdsh_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_thr       (thr)
    );

    fdsh_level_step u_step (
        .i_level        (r_level),
        .i_fault_status (r_fault_status),
        .i_temps_ok     (r_temps_ok),
        .i_temp_a       (r_temp_a),
        .i_temp_b       (r_temp_b),
        .i_thr          (thr),
        .o_level        (n_level),
        .o_write_issued (n_write_issued)
    );

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_fire    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_level     <= fdsh_pkg::LEVEL_MIN;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_level     <= n_level;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_fault_status <= i_in.fault_status;
            r_temps_ok     <= i_in.temps_ok;
            r_temp_a       <= i_in.temp_a;
            r_temp_b       <= i_in.temp_b;
        end
        if (advance) begin
            r_duty_code    <= fdsh_pkg::level_code(n_level);
            r_duty_percent <= fdsh_pkg::level_pct(n_level);
            r_write_issued <= n_write_issued;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.duty_code    = r_duty_code;
    assign o_out.duty_percent = r_duty_percent;
    assign o_out.write_issued = r_write_issued;

    a_fault_forces_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_fault_status != '0)) |=> (r_level == fdsh_pkg::LEVEL_MAX))
        else $error("fault tick did not force the top duty level");

    a_bad_read_keeps_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_fault_status == '0) && !r_temps_ok) |=> $stable(r_level))
        else $error("failed sensor read changed the duty level");

    a_level_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_level))
        else $error("duty level moved without a tick");

    a_result_matches_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_duty_code == fdsh_pkg::level_code(r_level)))
        else $error("result code does not match the stored level");

    a_code_pct_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |->
            ((r_duty_code == fdsh_pkg::CODE_LEVEL0) && (r_duty_percent == fdsh_pkg::PCT_LEVEL0)) ||
            ((r_duty_code == fdsh_pkg::CODE_LEVEL1) && (r_duty_percent == fdsh_pkg::PCT_LEVEL1)) ||
            ((r_duty_code == fdsh_pkg::CODE_LEVEL2) && (r_duty_percent == fdsh_pkg::PCT_LEVEL2)) ||
            ((r_duty_code == fdsh_pkg::CODE_LEVEL3) && (r_duty_percent == fdsh_pkg::PCT_LEVEL3)))
        else $error("duty code and percent disagree");

endmodule
